### src/tfsa_pkg.sv
// Shared constants for the typed first-fit slot allocator.
// No dependencies; used by the top level only.
package tfsa_pkg;

	// Width of the slot-count configuration register
	localparam int unsigned CFG_BITS = 5;

	// Slot count after reset
	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd10;

	// Width of the reported slot index (index is taken modulo 16)
	localparam int unsigned SLOT_INDEX_BITS = 4;

endpackage

### src/tfsa_slot_store.sv
// Slot store for the typed first-fit slot allocator: busy-until times and
// classes in a one-write, one-read memory, plus claimed bits in flops.
// Depends on nothing else; instantiated by typed_first_fit_slot_allocator.
module tfsa_slot_store #(
	parameter int unsigned MAX_SLOTS  = 16,
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned CLASS_BITS = 8,
	parameter int unsigned IDX_BITS   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// write port: claims the slot and stores its new busy-until time
	input  logic                  wr_en,
	input  logic [IDX_BITS-1:0]   wr_addr,
	input  logic [TIME_BITS-1:0]  wr_busy,
	input  logic [CLASS_BITS-1:0] wr_class,
	// read port: data is registered and shows up in the cycle after the address
	input  logic [IDX_BITS-1:0]   rd_addr,
	output logic [TIME_BITS-1:0]  rd_busy_q,
	output logic [CLASS_BITS-1:0] rd_class_q,
	output logic                  rd_claimed_q
);

	logic [TIME_BITS-1:0]  busy_mem  [MAX_SLOTS];
	logic [CLASS_BITS-1:0] class_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]  claimed_q;

	// Memory write; entries of unclaimed slots are never used
	always_ff @(posedge clk) begin
		if (wr_en) begin
			busy_mem[wr_addr]  <= wr_busy;
			class_mem[wr_addr] <= wr_class;
		end
	end

	// Registered memory read
	always_ff @(posedge clk) begin
		rd_busy_q  <= busy_mem[rd_addr];
		rd_class_q <= class_mem[rd_addr];
	end

	// Claimed bits: cleared at reset, gate the memory contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q    <= '0;
			rd_claimed_q <= 1'b0;
		end else begin
			if (wr_en) begin
				claimed_q[wr_addr] <= 1'b1;
			end
			rd_claimed_q <= claimed_q[rd_addr];
		end
	end

endmodule

### src/typed_first_fit_slot_allocator.sv
// Typed first-fit slot allocator: one request in, one grant result out.
// Depends on tfsa_pkg and tfsa_slot_store.
//
// A request is taken when start is high and busy is low. The block walks the
// slots from index 0 with one comparator, one slot per cycle, fed by the
// single read port of the slot store; it stops at the first slot that is
// unclaimed or holds the same class and is free by start_time. The result is
// on granted and slot_index for exactly one cycle with done high, and must be
// captured then: the receiver cannot hold it off. A scan covers at most
// min(slots_in_use, MAX_SLOTS) slots; with a slot count of zero it is
// refused without a scan. busy is low again in the cycle that done is high,
// so the next request may be taken there. cfg_we/cfg_wdata set slots_in_use
// and must only be used while busy and done are low. No clearing pass.
module typed_first_fit_slot_allocator #(
	parameter int unsigned MAX_SLOTS  = 16,
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned CLASS_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request side
	input  logic                                 start,
	output logic                                 busy,
	input  logic [TIME_BITS-1:0]                 start_time,
	input  logic [TIME_BITS-1:0]                 hold_duration,
	input  logic [CLASS_BITS-1:0]                class_code,
	// result side
	output logic                                 done,
	output logic                                 granted,
	output logic [tfsa_pkg::SLOT_INDEX_BITS-1:0] slot_index,
	// configuration
	input  logic                                 cfg_we,
	input  logic [tfsa_pkg::CFG_BITS-1:0]        cfg_wdata
);

	localparam int unsigned IDX_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CNT_BITS = $clog2(MAX_SLOTS + 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                        state_q;
	logic [tfsa_pkg::CFG_BITS-1:0] slots_in_use_q;
	logic [TIME_BITS-1:0]          start_q;
	logic [TIME_BITS-1:0]          end_q;
	logic [CLASS_BITS-1:0]         cls_q;
	logic [IDX_BITS-1:0]           idx_q;
	logic [CNT_BITS-1:0]           limit_q;
	logic                          done_q;
	logic                          granted_q;
	logic [tfsa_pkg::SLOT_INDEX_BITS-1:0] slot_index_q;

	logic                  accept;
	logic [TIME_BITS:0]    sum_c;
	logic [TIME_BITS-1:0]  end_c;
	logic [CNT_BITS-1:0]   limit_c;
	logic                  take_c;
	logic                  last_c;
	logic                  wr_en;
	logic [IDX_BITS-1:0]   rd_addr;
	logic [TIME_BITS-1:0]  rd_busy;
	logic [CLASS_BITS-1:0] rd_class;
	logic                  rd_claimed;

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign granted    = granted_q;
	assign slot_index = slot_index_q;
	assign accept     = start && !busy;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= tfsa_pkg::CFG_RESET;
		end else if (cfg_we) begin
			slots_in_use_q <= cfg_wdata;
		end
	end

	// Saturating end time and clamped slot count, computed at request accept
	always_comb begin
		sum_c = {1'b0, start_time} + {1'b0, hold_duration};
		end_c = sum_c[TIME_BITS] ? '1 : sum_c[TIME_BITS-1:0];
		if (32'(slots_in_use_q) > 32'(MAX_SLOTS)) begin
			limit_c = CNT_BITS'(MAX_SLOTS);
		end else begin
			limit_c = CNT_BITS'(slots_in_use_q);
		end
	end

	// Shared fit check on the slot currently read out
	always_comb begin
		take_c = !rd_claimed || ((rd_class == cls_q) && (start_q >= rd_busy));
		last_c = ((CNT_BITS'(idx_q) + 1'b1) == limit_q);
		wr_en  = (state_q == ST_SCAN) && take_c;
	end

	// Read slot 0 while idle, the next slot while scanning
	assign rd_addr = (state_q == ST_SCAN) ? (idx_q + 1'b1) : '0;

	// Sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			granted_q    <= 1'b0;
			slot_index_q <= '0;
			idx_q        <= '0;
			limit_q      <= '0;
			start_q      <= '0;
			end_q        <= '0;
			cls_q        <= '0;
		end else begin
			done_q       <= 1'b0;
			granted_q    <= 1'b0;
			slot_index_q <= '0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_q <= start_time;
						end_q   <= end_c;
						cls_q   <= class_code;
						limit_q <= limit_c;
						idx_q   <= '0;
						if (limit_c == '0) begin
							// nothing to scan: refuse at once
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (take_c) begin
						done_q       <= 1'b1;
						granted_q    <= 1'b1;
						slot_index_q <= tfsa_pkg::SLOT_INDEX_BITS'(idx_q);
						state_q      <= ST_IDLE;
					end else if (last_c) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	tfsa_slot_store #(
		.MAX_SLOTS (MAX_SLOTS),
		.TIME_BITS (TIME_BITS),
		.CLASS_BITS(CLASS_BITS),
		.IDX_BITS  (IDX_BITS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_addr     (idx_q),
		.wr_busy     (end_q),
		.wr_class    (cls_q),
		.rd_addr     (rd_addr),
		.rd_busy_q   (rd_busy),
		.rd_class_q  (rd_class),
		.rd_claimed_q(rd_claimed)
	);

	// A result is only issued once the scan has ended
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while still scanning");

	// A grant or a nonzero index only comes with the strobe
	a_grant_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(granted || (slot_index != '0)) |-> done)
		else $error("grant fields set without done");

	// An accepted request either starts a scan or is refused next cycle
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || (done && !granted)))
		else $error("accepted request neither scanned nor refused");

	// The scan stays inside the configured slot range
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_BITS'(idx_q) < limit_q))
		else $error("scan index beyond slot count");

endmodule
